[src/nearest_point_search_3d_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the nearest point search block
// Shared property templates; every user has clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_3D_ASSERT_SVH
`define NEAREST_POINT_SEARCH_3D_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/nps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// Shared constants and command type for the nearest point search block.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int MAX_TARGETS_DEF = 4096;
  localparam int COORD_BITS_DEF  = 18;

  // Input kind codes
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Decoded command passed from front to back
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

endpackage

[src/nps_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_front
// Accepts input beats, decodes the kind and registers a command; unused kind
// codes are dropped here.
// ----------------------------------------------------------------------------
module nps_front #(
  parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              kind,
  input  logic [3*COORD_BITS-1:0] point,
  output logic                    cmd_valid,
  input  logic                    cmd_ready,
  output nps_pkg::op_t            cmd_op,
  output logic [3*COORD_BITS-1:0] cmd_point
);

  logic         hold_valid;
  logic         take;
  logic         keep;
  nps_pkg::op_t dec_op;

  assign in_ready  = !hold_valid || cmd_ready;
  assign take      = in_valid && in_ready;
  assign cmd_valid = hold_valid;

  // Decode kind; code three carries no work
  always_comb begin
    dec_op = nps_pkg::OP_LOAD;
    keep   = 1'b1;
    unique case (kind)
      nps_pkg::KIND_LOAD:  dec_op = nps_pkg::OP_LOAD;
      nps_pkg::KIND_QUERY: dec_op = nps_pkg::OP_QUERY;
      nps_pkg::KIND_CLEAR: dec_op = nps_pkg::OP_CLEAR;
      default:             keep   = 1'b0;
    endcase
  end

  // Hold the decoded command until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= keep;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_op    <= dec_op;
      cmd_point <= point;
    end
  end

endmodule

[src/nps_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_cmd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module nps_cmd_queue #(
  parameter int WIDTH = 2 + 3 * nps_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

[src/nps_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_back
// Executes commands: owns the target memory and count, appends loads,
// clears, and scans all targets through a distance pipeline for queries.
// ----------------------------------------------------------------------------
`include "nearest_point_search_3d_assert.svh"

module nps_back #(
  parameter int MAX_TARGETS = nps_pkg::MAX_TARGETS_DEF,
  parameter int COORD_BITS  = nps_pkg::COORD_BITS_DEF,
  localparam int IDX_W      = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1,
  localparam int DIST_W     = 2 * COORD_BITS + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  nps_pkg::op_t            cmd_op,
  input  logic [3*COORD_BITS-1:0] cmd_point,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [1:0]              res_status,
  output logic [3*COORD_BITS-1:0] res_point,
  output logic [IDX_W-1:0]        res_index,
  output logic [DIST_W-1:0]       res_dist
);

  localparam int CB    = COORD_BITS;
  localparam int PT_W  = 3 * CB;
  localparam int CNT_W = $clog2(MAX_TARGETS + 1);
  localparam int SQ_W  = 2 * CB;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic signed [CB:0] d;
    d = signed'({a[CB-1], a}) - signed'({b[CB-1], b});
    return d[CB] ? CB'(-d) : CB'(d);
  endfunction

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_idx;
  logic [PT_W-1:0]   qpt;
  logic [PT_W-1:0]   mem [MAX_TARGETS];
  logic              full;
  logic              out_free;
  logic              pop;
  logic              emit;
  logic              last_issue;

  // Scan pipeline stages
  logic              v1, v2, v3, v4;
  logic [IDX_W-1:0]  i1, i2, i3, i4;
  logic [PT_W-1:0]   pt1, pt2, pt3, pt4;
  logic [CB-1:0]     ax, ay, az;
  logic [SQ_W-1:0]   sqx, sqy, sqz;
  logic [DIST_W-1:0] sum4;

  // Running best
  logic [DIST_W-1:0] best_d;
  logic [IDX_W-1:0]  best_i;
  logic [PT_W-1:0]   best_pt;

  assign full       = (count == CNT_W'(MAX_TARGETS));
  assign out_free   = !res_valid || res_ready;
  assign last_issue = (rd_idx == count - CNT_W'(1));

  // Take a command only when it can finish without blocking
  always_comb begin
    cmd_ready = 1'b0;
    if (state == S_IDLE) begin
      unique case (cmd_op)
        nps_pkg::OP_LOAD:  cmd_ready = !full || out_free;
        nps_pkg::OP_QUERY: cmd_ready = (count != '0) || out_free;
        nps_pkg::OP_CLEAR: cmd_ready = 1'b1;
        default:           cmd_ready = 1'b0;
      endcase
    end
  end
  assign pop = cmd_valid && cmd_ready;

  // Result emitted this cycle: empty query, full load or scan end
  always_comb begin
    emit = 1'b0;
    if (pop) begin
      emit = (cmd_op == nps_pkg::OP_LOAD && full) ||
             (cmd_op == nps_pkg::OP_QUERY && count == '0);
    end else if (state == S_DONE) begin
      emit = out_free;
    end
  end

  // Sequence the command
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop && cmd_op == nps_pkg::OP_QUERY && count != '0) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!(v1 || v2 || v3 || v4)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (pop && cmd_op == nps_pkg::OP_CLEAR) begin
        count <= '0;
      end else if (pop && cmd_op == nps_pkg::OP_LOAD && !full) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Latch the query point; advance the scan address
  always_ff @(posedge clk) begin
    if (pop) begin
      qpt    <= cmd_point;
      rd_idx <= '0;
    end else if (state == S_SCAN) begin
      rd_idx <= rd_idx + CNT_W'(1);
    end
  end

  // Target memory: append on load, read one entry a cycle during a scan
  always_ff @(posedge clk) begin
    if (pop && cmd_op == nps_pkg::OP_LOAD && !full) begin
      mem[count[IDX_W-1:0]] <= cmd_point;
    end
    pt1 <= mem[rd_idx[IDX_W-1:0]];
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= (state == S_SCAN);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Differences, squares, sum
  always_ff @(posedge clk) begin
    i1  <= rd_idx[IDX_W-1:0];
    ax  <= abs_diff(qpt[CB-1:0], pt1[CB-1:0]);
    ay  <= abs_diff(qpt[2*CB-1:CB], pt1[2*CB-1:CB]);
    az  <= abs_diff(qpt[3*CB-1:2*CB], pt1[3*CB-1:2*CB]);
    i2  <= i1;
    pt2 <= pt1;
    sqx <= ax * ax;
    sqy <= ay * ay;
    sqz <= az * az;
    i3  <= i2;
    pt3 <= pt2;
    sum4 <= DIST_W'(sqx) + DIST_W'(sqy) + DIST_W'(sqz);
    i4  <= i3;
    pt4 <= pt3;
  end

  // Keep the first strict minimum
  always_ff @(posedge clk) begin
    if (v4 && (i4 == '0 || sum4 < best_d)) begin
      best_d  <= sum4;
      best_i  <= i4;
      best_pt <= pt4;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (state == S_DONE) begin
        res_status <= nps_pkg::ST_FOUND;
        res_point  <= best_pt;
        res_index  <= best_i;
        res_dist   <= best_d;
      end else begin
        res_status <= (cmd_op == nps_pkg::OP_LOAD) ? nps_pkg::ST_FULL : nps_pkg::ST_EMPTY;
        res_point  <= '0;
        res_index  <= '0;
        res_dist   <= '0;
      end
    end
  end

  `NPS_ASSERT_IMPL(a_count_max, 1'b1, count <= CNT_W'(MAX_TARGETS), "target count overflow")
  `NPS_ASSERT_IMPL(a_no_overwrite, res_valid && !res_ready, !emit, "result overwritten")
  `NPS_ASSERT_IMPL(a_idle_empty, state == S_IDLE, !(v1 || v2 || v3 || v4), "scan left busy")
  `NPS_ASSERT_NEXT(a_count_hold, state == S_SCAN, $stable(count), "count moved during scan")

endmodule

[src/nearest_point_search_3d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_search_3d
// Brute-force 3D nearest neighbor search over a store of target points.
// ----------------------------------------------------------------------------
// A load beat appends a point to the target store (or reports status full and
// drops it), a clear beat empties the store, and a query beat returns the
// first stored target with the smallest squared distance. Every beat first
// enters the front register, which drops unused kind codes, and the others
// pass through the command queue. Loads and clears then finish as the back
// accepts them, and an empty or full answer is loaded into the result
// register as the back accepts its beat. For a query over N stored targets,
// the single read port of the target memory delivers one target per cycle
// into a four-stage distance pipeline, which then drains before the result
// register loads. A two-entry command queue lets new beats be accepted while
// a scan or a waiting result is in progress.
module nearest_point_search_3d #(
  parameter int MAX_TARGETS = nps_pkg::MAX_TARGETS_DEF,
  parameter int COORD_BITS  = nps_pkg::COORD_BITS_DEF,
  localparam int IDX_W      = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1,
  localparam int DIST_W     = 2 * COORD_BITS + 2,
  localparam int IN_W       = ((3 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((3 * COORD_BITS + IDX_W + DIST_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // point_x, point_y, point_z, zero pad
  input  logic [1:0]       s_tuser,   // kind
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // nearest_x, nearest_y, nearest_z,
                                      // nearest_index, min_distance, zero pad
  output logic [1:0]       m_tuser    // status
);

  localparam int PT_W = 3 * COORD_BITS;
  localparam int Q_W  = PT_W + 2;

  logic                front_valid;
  logic                front_ready;
  nps_pkg::op_t        front_op;
  logic [PT_W-1:0]     front_point;
  logic                cmd_valid;
  logic                cmd_ready;
  logic [Q_W-1:0]      cmd_data;
  logic [PT_W-1:0]     res_point;
  logic [IDX_W-1:0]    res_index;
  logic [DIST_W-1:0]   res_dist;

  nps_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .kind      (s_tuser),
    .point     (s_tdata[PT_W-1:0]),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd_op    (front_op),
    .cmd_point (front_point)
  );

  nps_cmd_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   ({front_point, front_op}),
    .out_valid (cmd_valid),
    .out_ready (cmd_ready),
    .out_data  (cmd_data)
  );

  nps_back #(
    .MAX_TARGETS (MAX_TARGETS),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_op     (nps_pkg::op_t'(cmd_data[1:0])),
    .cmd_point  (cmd_data[Q_W-1:2]),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_status (m_tuser),
    .res_point  (res_point),
    .res_index  (res_index),
    .res_dist   (res_dist)
  );

  // Pack result fields, lowest first, zero padded
  assign m_tdata = OUT_W'({res_dist, res_index, res_point});

endmodule

[verif/tb_nearest_point_search_3d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_point_search_3d
// Self-checking bench for the 3D nearest point search block.
// ----------------------------------------------------------------------------
// A stimulus process queues command beats: a directed opening (empty store,
// coordinate extremes, ties, duplicates, the ignored kind code) and random
// clear/load/query sequences with some noise. A clocked driver offers the
// beats with random gaps. A scoreboard model of the target store predicts
// each query and full-store answer on acceptance. A clocked monitor with
// random back-pressure checks every answer beat in order. One long receiver
// hold-off and one sender drain pause are included.
// ----------------------------------------------------------------------------
module tb_nearest_point_search_3d;

  localparam int MAX_TGT      = nps_pkg::MAX_TARGETS_DEF;
  localparam int IN_W         = 56;
  localparam int OUT_W        = 104;
  localparam int TOTAL_ITEMS  = 140;
  localparam int CALM_FROM    = 50;
  localparam int CALM_TO      = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 13;
  localparam int TAIL_CYCLES  = MAX_TGT + 100;
  localparam int MAX_REPORTS  = 10;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [17:0] COORD_MAX = 18'h1ffff;
  localparam logic [17:0] COORD_MIN = 18'h20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [17:0] x;
    logic [17:0] y;
    logic [17:0] z;
    logic        drain_first;
    logic        hold_rx;
    logic        calm;
  } command_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [17:0] x;
    logic [17:0] y;
    logic [17:0] z;
    logic [11:0] index;
    logic [37:0] sq_dist;
  } answer_t;

  logic             clk;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic [1:0]       s_tuser  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;

  nearest_point_search_3d dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Command beats waiting to be driven, answers waiting to arrive
  command_t command_queue[$];
  answer_t  answers_due[$];

  // Scoreboard copy of the target store
  logic signed [17:0] tgt_x [MAX_TGT];
  logic signed [17:0] tgt_y [MAX_TGT];
  logic signed [17:0] tgt_z [MAX_TGT];
  int                 target_total = 0;

  command_t active_cmd = '0;
  logic     calm_now   = 1'b0;
  int       hold_left  = 0;
  int       error_count = 0;

  // Flags copied into each queued beat; the two mark flags clear once used
  bit mark_drain = 1'b0;
  bit mark_hold  = 1'b0;
  bit calm_zone  = 1'b0;
  int counted_items = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("nearest_point_search_3d regression: fail");
    $finish;
  end

  task automatic push_cmd(input logic [1:0] kind, input logic [17:0] x,
                          input logic [17:0] y, input logic [17:0] z);
    command_t cmd;
    cmd.kind        = kind;
    cmd.x           = x;
    cmd.y           = y;
    cmd.z           = z;
    cmd.drain_first = mark_drain;
    cmd.hold_rx     = mark_hold;
    cmd.calm        = calm_zone;
    mark_drain      = 1'b0;
    mark_hold       = 1'b0;
    command_queue.insert(command_queue.size(), cmd);
    counted_items++;
  endtask

  // Span 0 draws the full coordinate range, otherwise +/- span
  function automatic logic [17:0] pick_coord(input int span);
    int v;
    if (span == 0) return 18'($urandom);
    v = int'($urandom_range(2 * span)) - span;
    return v[17:0];
  endfunction

  // Update the store model and queue the answer a command produces
  task automatic predict_nearest(input command_t cmd);
    answer_t ans;
    longint  dx, dy, dz, d, best_d;
    int      best_i;
    ans = '0;
    case (cmd.kind)
      nps_pkg::KIND_LOAD: begin
        if (target_total >= MAX_TGT) begin
          ans.status = nps_pkg::ST_FULL;
          answers_due.insert(answers_due.size(), ans);
        end else begin
          tgt_x[target_total] = cmd.x;
          tgt_y[target_total] = cmd.y;
          tgt_z[target_total] = cmd.z;
          target_total++;
        end
      end
      nps_pkg::KIND_CLEAR: target_total = 0;
      nps_pkg::KIND_QUERY: begin
        if (target_total == 0) begin
          ans.status = nps_pkg::ST_EMPTY;
        end else begin
          best_i = 0;
          best_d = 0;
          for (int i = 0; i < target_total; i++) begin
            dx = longint'($signed(cmd.x)) - longint'(tgt_x[i]);
            dy = longint'($signed(cmd.y)) - longint'(tgt_y[i]);
            dz = longint'($signed(cmd.z)) - longint'(tgt_z[i]);
            d  = dx * dx + dy * dy + dz * dz;
            // strict less-than keeps the lowest index on ties
            if (i == 0 || d < best_d) begin
              best_d = d;
              best_i = i;
            end
          end
          ans.status  = nps_pkg::ST_FOUND;
          ans.x       = tgt_x[best_i];
          ans.y       = tgt_y[best_i];
          ans.z       = tgt_z[best_i];
          ans.index   = best_i[11:0];
          ans.sq_dist = best_d[37:0];
        end
        answers_due.insert(answers_due.size(), ans);
      end
      default: ;  // unused kind: ignored by the block
    endcase
  endtask

  task automatic report_error(input string why, input answer_t want,
                              input answer_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, why);
      $display("  expected st %0d xyz %0d %0d %0d idx %0d dist %0d", want.status,
               $signed(want.x), $signed(want.y), $signed(want.z), want.index,
               want.sq_dist);
      $display("  actual   st %0d xyz %0d %0d %0d idx %0d dist %0d", got.status,
               $signed(got.x), $signed(got.y), $signed(got.z), got.index,
               got.sq_dist);
    end
  endtask

  // Offer queued beats; predict on every accepted beat
  always @(posedge clk) begin : drive_commands
    command_t next_cmd;
    logic     offer;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_nearest(active_cmd);
      if (!s_tvalid || s_tready) begin
        offer = 1'b0;
        if (command_queue.size() != 0) begin
          next_cmd = command_queue[0];
          offer = 1'b1;
          if (next_cmd.drain_first && answers_due.size() != 0) offer = 1'b0;
          if (!next_cmd.calm && $urandom_range(99) < IDLE_PCT) offer = 1'b0;
        end
        if (offer) begin
          void'(command_queue.pop_front());
          active_cmd <= next_cmd;
          s_tdata    <= {2'b00, next_cmd.z, next_cmd.y, next_cmd.x};
          s_tuser    <= next_cmd.kind;
          calm_now   <= next_cmd.calm;
          s_tvalid   <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Count down the long receiver hold-off
  always @(posedge clk) begin : hold_counter
    if (rst) begin
      hold_left <= 0;
    end else if (s_tvalid && s_tready && active_cmd.hold_rx) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Accept answer beats and compare with the oldest prediction
  always @(posedge clk) begin : check_answers
    answer_t got;
    answer_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status  = m_tuser;
        got.x       = m_tdata[17:0];
        got.y       = m_tdata[35:18];
        got.z       = m_tdata[53:36];
        got.index   = m_tdata[65:54];
        got.sq_dist = m_tdata[103:66];
        if (answers_due.size() == 0) begin
          report_error("answer beat with nothing expected", '0, got);
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status || got.x !== want.x || got.y !== want.y ||
              got.z !== want.z || got.index !== want.index ||
              got.sq_dist !== want.sq_dist) begin
            report_error("answer mismatch", want, got);
          end
        end
      end
      m_tready <= (hold_left == 0) && (calm_now || $urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    logic [17:0] seq_x[$];
    logic [17:0] seq_y[$];
    logic [17:0] seq_z[$];
    int          seq;
    int          span;
    int          n;
    int          k;
    logic [1:0]  kind;

    // Directed opening: empty store, extremes, ties, duplicates, unused kind
    push_cmd(nps_pkg::KIND_QUERY, 18'd0, 18'd0, 18'd0);
    push_cmd(KIND_UNUSED, 18'd1, 18'd2, 18'd3);
    push_cmd(nps_pkg::KIND_LOAD, COORD_MAX, COORD_MAX, COORD_MAX);
    push_cmd(nps_pkg::KIND_QUERY, COORD_MIN, COORD_MIN, COORD_MIN);
    push_cmd(nps_pkg::KIND_LOAD, COORD_MIN, COORD_MIN, COORD_MIN);
    push_cmd(nps_pkg::KIND_QUERY, COORD_MIN, COORD_MIN, COORD_MIN);
    push_cmd(nps_pkg::KIND_QUERY, COORD_MAX, COORD_MIN, 18'd0);
    push_cmd(nps_pkg::KIND_CLEAR, 18'd0, 18'd0, 18'd0);
    push_cmd(nps_pkg::KIND_QUERY, 18'd5, 18'd5, 18'd5);
    push_cmd(nps_pkg::KIND_LOAD, 18'd64, 18'd0, 18'd0);
    push_cmd(nps_pkg::KIND_LOAD, -18'sd64, 18'd0, 18'd0);
    push_cmd(nps_pkg::KIND_LOAD, 18'd0, 18'd64, 18'd0);
    push_cmd(nps_pkg::KIND_QUERY, 18'd0, 18'd0, 18'd0);
    push_cmd(nps_pkg::KIND_LOAD, 18'd64, 18'd0, 18'd0);
    push_cmd(nps_pkg::KIND_QUERY, 18'd64, 18'd0, 18'd0);
    push_cmd(nps_pkg::KIND_LOAD, 18'h15555, 18'h2aaaa, 18'h15555);
    push_cmd(nps_pkg::KIND_QUERY, 18'h2aaaa, 18'h15555, 18'h2aaaa);
    push_cmd(KIND_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX);
    push_cmd(nps_pkg::KIND_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX);
    push_cmd(nps_pkg::KIND_CLEAR, 18'd0, 18'd0, 18'd0);
    push_cmd(nps_pkg::KIND_LOAD, 18'h3ffff, 18'h3ffff, 18'h3ffff);
    push_cmd(nps_pkg::KIND_QUERY, 18'd0, 18'd0, 18'd0);

    // Back-pressure: hold the receiver while queries keep coming
    push_cmd(nps_pkg::KIND_CLEAR, 18'd0, 18'd0, 18'd0);
    for (int i = 0; i < 6; i++) push_cmd(nps_pkg::KIND_LOAD, pick_coord(0),
                                         pick_coord(0), pick_coord(0));
    mark_hold = 1'b1;
    for (int i = 0; i < 10; i++) push_cmd(nps_pkg::KIND_QUERY, pick_coord(0),
                                          pick_coord(0), pick_coord(0));

    // Random sequences: mostly clear/load/query runs, some noise
    seq = 0;
    while (counted_items < TOTAL_ITEMS) begin
      calm_zone = (counted_items >= CALM_FROM && counted_items < CALM_TO);
      if (seq == 1) mark_drain = 1'b1;
      if ($urandom_range(99) < 75) begin
        case ($urandom_range(2))
          0:       span = 0;
          1:       span = 64;
          default: span = 4000;
        endcase
        seq_x.delete();
        seq_y.delete();
        seq_z.delete();
        push_cmd(nps_pkg::KIND_CLEAR, pick_coord(0), pick_coord(0), pick_coord(0));
        n = $urandom_range(16);
        for (int i = 0; i < n; i++) begin
          if (i != 0 && $urandom_range(99) < 15) begin
            // duplicate an earlier point to exercise ties
            k = $urandom_range(i - 1);
            seq_x.insert(seq_x.size(), seq_x[k]);
            seq_y.insert(seq_y.size(), seq_y[k]);
            seq_z.insert(seq_z.size(), seq_z[k]);
          end else begin
            seq_x.insert(seq_x.size(), pick_coord(span));
            seq_y.insert(seq_y.size(), pick_coord(span));
            seq_z.insert(seq_z.size(), pick_coord(span));
          end
          push_cmd(nps_pkg::KIND_LOAD, seq_x[i], seq_y[i], seq_z[i]);
        end
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          if (seq_x.size() != 0 && $urandom_range(99) < 30) begin
            k = $urandom_range(seq_x.size() - 1);
            push_cmd(nps_pkg::KIND_QUERY, seq_x[k], seq_y[k], seq_z[k]);
          end else begin
            push_cmd(nps_pkg::KIND_QUERY, pick_coord(span), pick_coord(span),
                     pick_coord(span));
          end
        end
      end else begin
        kind = 2'($urandom_range(3));
        push_cmd(kind, pick_coord(0), pick_coord(0), pick_coord(0));
      end
      seq++;
    end
    calm_zone = 1'b0;

    // Release reset and let the driver run
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (command_queue.size() != 0 || s_tvalid);
    do @(negedge clk); while (answers_due.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (answers_due.size() != 0) begin
      error_count++;
      $display("%0d expected answers never arrived", answers_due.size());
    end
    if (error_count == 0) begin
      $display("nearest_point_search_3d regression: pass");
    end else begin
      $display("nearest_point_search_3d regression: fail");
    end
    $finish;
  end

endmodule
